/* rtl/rhpq_pkg.sv */
// ----------------------------------------------------------------------------
// rhpq_pkg
// Shared types, constants and codes of the monotone priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 31;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENT_W    = KEY_W + 1;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 3;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 88;

  localparam logic [KEY_W-1:0] NO_KEY = {KEY_W{1'b1}};

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELMIN = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MODIFY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STAT_W-1:0] ST_SMALL   = 3'd4;

  typedef enum logic [2:0] {
    S_RST_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OP_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic sweep;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic is_clear;
    logic sweep_last;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/radix_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// radix_heap_priority_queue
// Monotone priority queue of element numbers keyed by 31-bit integers.
// ----------------------------------------------------------------------------
//  channel   dir  signals                        contents
//  s_axis    in   s_tvalid s_tready s_tdata      operation
//  m_axis    out  m_tvalid m_tready m_tdata      result
//  cfg       in   cfg_valid cfg_ready cfg_data   start_last_key
//
// Operations without a scan (push, query, a modify of an element that is not
// the current minimum, rejected and unused operations) go from execute
// straight to the result. Delete-min and a modify of the current minimum
// scan the entry RAM at one entry per cycle through its single read port;
// clear sweeps every entry of the entry RAM.
// After reset a clearing pass over all 1024 entries runs before the first
// operation is taken; configuration writes are taken at any time.
// A finished result waits in the output register; a new operation is taken
// once the previous result has moved into that register.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_heap_priority_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // func[2:0], elem[12:3], new_key[43:13], zero fill
  input  wire logic [rhpq_pkg::IN_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // out_elem[9:0], out_key[40:10], old_key[71:41], is_present[72],
  // count[83:73], status[86:84], zero fill
  output logic [rhpq_pkg::OUT_W-1:0]       m_tdata,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rhpq_pkg::KEY_W-1:0]  cfg_data
);

  import rhpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rhpq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

/* rtl/rhpq_ram.sv */
// ----------------------------------------------------------------------------
// rhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/rhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// rhpq_ctrl
// Sequencer of the priority queue: sweep, execute, scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rhpq_pkg::sts_t sts,
  output rhpq_pkg::cmd_t     cmd
);

  import rhpq_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_RST_CLEAR: if (sts.sweep_last) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        priority if (sts.is_clear) state_next = S_OP_CLEAR;
        else if (sts.need_scan)    state_next = S_SCAN;
        else                       state_next = S_DONE;
      end
      S_SCAN:      if (sts.scan_end) state_next = S_DONE;
      S_OP_CLEAR:  if (sts.sweep_last) state_next = S_DONE;
      S_DONE:      if (sts.out_free) state_next = S_IDLE;
      default:     state_next = S_RST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_RST_CLEAR: cmd.sweep = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EXEC:      cmd.exec = 1'b1;
      S_SCAN:      cmd.scan = 1'b1;
      S_OP_CLEAR:  cmd.sweep = 1'b1;
      S_DONE:      cmd.load_out = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rhpq_dp.sv */
// ----------------------------------------------------------------------------
// rhpq_dp
// Datapath: entry RAM, minimum tracking, scan compare and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rhpq_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [rhpq_pkg::IN_W-1:0] in_data,
  input  wire logic                     cfg_valid,
  input  wire logic [rhpq_pkg::KEY_W-1:0] cfg_data,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [rhpq_pkg::OUT_W-1:0]    out_data,
  input  wire rhpq_pkg::cmd_t           cmd,
  output rhpq_pkg::sts_t                sts
);

  import rhpq_pkg::*;

  // configuration and queue state
  logic [KEY_W-1:0]  start_key;
  logic [KEY_W-1:0]  last_key;
  logic [CNT_W-1:0]  elem_count;
  logic [KEY_W-1:0]  min_key;
  logic [IDX_W-1:0]  min_elem;
  logic              found;

  // latched operation
  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  elem_q;
  logic [KEY_W-1:0]  key_q;

  // sweep / scan counter and compare stage
  logic [CNT_W-1:0]  cnt;
  logic              cmp_v;
  logic [IDX_W-1:0]  cmp_idx;

  // result holding
  logic [IDX_W-1:0]  res_elem;
  logic [KEY_W-1:0]  res_key;
  logic [KEY_W-1:0]  res_prev;
  logic              res_pres;
  logic [STAT_W-1:0] res_stat;

  // RAM ports
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_data;
  logic              rd_pres;
  logic [KEY_W-1:0]  rd_key;

  // execute decisions
  logic              ok_push;
  logic              ok_del;
  logic              ok_mod;
  logic              take_new;

  assign rd_pres = rd_data[ENT_W-1];
  assign rd_key  = rd_data[KEY_W-1:0];

  rhpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // decode the operation outcome from the stored entry
  always_comb begin
    ok_push  = (func_q == FN_PUSH) && !rd_pres && (key_q >= last_key);
    ok_del   = (func_q == FN_DELMIN) && (elem_count != '0);
    ok_mod   = (func_q == FN_MODIFY) && rd_pres && (key_q >= last_key);
    take_new = (elem_count == '0) || (key_q < min_key) ||
               ((key_q == min_key) && (elem_q < min_elem));
  end

  // RAM address and write selection
  always_comb begin
    rd_addr = cnt[IDX_W-1:0];
    if (cmd.latch) begin
      rd_addr = in_data[3 +: IDX_W];
    end
    wr_en   = 1'b0;
    wr_addr = cnt[IDX_W-1:0];
    wr_data = '0;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.exec) begin
      if (ok_push || ok_mod) begin
        wr_en   = 1'b1;
        wr_addr = elem_q;
        wr_data = {1'b1, key_q};
      end else if (ok_del) begin
        wr_en   = 1'b1;
        wr_addr = min_elem;
      end
    end
  end

  // status back to the sequencer
  always_comb begin
    sts.need_scan  = ok_del || (ok_mod && (elem_q == min_elem));
    sts.is_clear   = (func_q == FN_CLEAR);
    sts.sweep_last = (cnt == CNT_W'(CAPACITY - 1));
    sts.scan_end   = (cnt == CNT_W'(CAPACITY));
    sts.out_free   = !out_valid || out_ready;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_key <= '0;
    end else if (cfg_valid) begin
      start_key <= cfg_data;
    end
  end

  // latch the incoming operation
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= in_data[0 +: FUNC_W];
      elem_q <= in_data[3 +: IDX_W];
      key_q  <= in_data[13 +: KEY_W];
    end
  end

  // counter and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= 1'b0;
      if (cmd.sweep) begin
        cnt <= sts.sweep_last ? '0 : cnt + 1'b1;
      end else if (cmd.exec) begin
        cnt <= '0;
      end else if (cmd.scan) begin
        if (!sts.scan_end) begin
          cmp_v   <= 1'b1;
          cmp_idx <= cnt[IDX_W-1:0];
          cnt     <= cnt + 1'b1;
        end
      end
    end
  end

  // queue state: count, last key, minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      last_key   <= '0;
      elem_count <= '0;
      min_key    <= NO_KEY;
      min_elem   <= '0;
      found      <= 1'b0;
    end else if (cmd.exec) begin
      if (ok_push) begin
        elem_count <= elem_count + 1'b1;
        if (take_new) begin
          min_key  <= key_q;
          min_elem <= elem_q;
        end
      end else if (ok_mod) begin
        if (elem_q == min_elem) begin
          min_key  <= NO_KEY;
          min_elem <= '0;
          found    <= 1'b0;
        end else if (take_new) begin
          min_key  <= key_q;
          min_elem <= elem_q;
        end
      end else if (ok_del) begin
        last_key   <= min_key;
        elem_count <= elem_count - 1'b1;
        min_key    <= NO_KEY;
        min_elem   <= '0;
        found      <= 1'b0;
      end else if (func_q == FN_CLEAR) begin
        last_key   <= start_key;
        elem_count <= '0;
        min_key    <= NO_KEY;
        min_elem   <= '0;
      end
    end else if (cmp_v && rd_pres && (!found || rd_key < min_key)) begin
      min_key  <= rd_key;
      min_elem <= cmp_idx;
      found    <= 1'b1;
    end
  end

  // capture result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_elem <= elem_q;
      res_key  <= NO_KEY;
      res_prev <= '0;
      res_pres <= 1'b0;
      res_stat <= ST_OK;
      unique case (func_q)
        FN_PUSH: begin
          priority if (rd_pres)      res_stat <= ST_PRESENT;
          else if (key_q < last_key) res_stat <= ST_SMALL;
          else                       res_key  <= key_q;
        end
        FN_DELMIN: begin
          if (elem_count == '0) begin
            res_stat <= ST_EMPTY;
          end else begin
            res_elem <= min_elem;
            res_key  <= min_key;
          end
        end
        FN_MODIFY: begin
          priority if (!rd_pres) begin
            res_stat <= ST_ABSENT;
          end else if (key_q < last_key) begin
            res_stat <= ST_SMALL;
          end else begin
            res_key  <= key_q;
            res_prev <= rd_key;
          end
        end
        FN_QUERY: begin
          if (rd_pres) begin
            res_pres <= 1'b1;
            res_key  <= rd_key;
          end
        end
        default: res_stat <= ST_OK;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {1'b0, res_stat, elem_count, res_pres, res_prev, res_key, res_elem};
    end
  end

endmodule

`default_nettype wire
